// File: design/ppstop_pkg.sv
`timescale 1ns / 1ps

package ppstop_pkg;

    // Table size and coordinate width.
    localparam int MAX_VEHICLES = 8;
    localparam int COORD_BITS   = 24;

    // Derived widths.
    localparam int IDX_BITS  = $clog2(MAX_VEHICLES);
    localparam int CNT_BITS  = $clog2(MAX_VEHICLES + 1);
    localparam int LIM_BITS  = 23;
    localparam int VIN_BITS  = 4;
    localparam int VIDX_BITS = 3;
    localparam int STOP_BITS = 8;
    localparam int OPW       = (COORD_BITS > LIM_BITS) ? COORD_BITS : LIM_BITS;
    localparam int PROD_W    = 2 * OPW;
    localparam int MASK_W    = (MAX_VEHICLES > STOP_BITS) ? MAX_VEHICLES : STOP_BITS;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 23;
    localparam logic [VIN_BITS-1:0] VIN_RESET = VIN_BITS'(8);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LIM_XY = 2'd0,
        CFG_LIM_Z  = 2'd1,
        CFG_VIN    = 2'd2
    } t_cfg_idx;

    // One table entry.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_pos;

    // Operation of the shared distance unit.
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LIM  = 3'd1,
        OP_DIFF = 3'd2,
        OP_SQX  = 3'd3,
        OP_SQY  = 3'd4
    } t_calc_op;

    // Table access requested by the sequencer.
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        logic [IDX_BITS-1:0] raddr_a;
        logic [IDX_BITS-1:0] raddr_b;
    } t_store_ctl;

endpackage

// File: design/ppstop_store.sv
`timescale 1ns / 1ps

module ppstop_store (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ppstop_pkg::t_store_ctl                i_ctl,
    input  ppstop_pkg::t_pos                      i_wdata,
    output ppstop_pkg::t_pos                      o_rdata_a,
    output ppstop_pkg::t_pos                      o_rdata_b,
    output logic [ppstop_pkg::MAX_VEHICLES-1:0]   o_valid
);

    ppstop_pkg::t_pos r_mem [ppstop_pkg::MAX_VEHICLES];
    ppstop_pkg::t_pos r_rd_a;
    ppstop_pkg::t_pos r_rd_b;
    logic [ppstop_pkg::MAX_VEHICLES-1:0] r_valid;

    // Position memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_ctl.raddr_a];
        r_rd_b <= r_mem[i_ctl.raddr_b];
    end

    // One valid bit per entry, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.waddr] <= 1'b1;
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
    assign o_valid   = r_valid;

endmodule

// File: design/ppstop_calc.sv
`timescale 1ns / 1ps

module ppstop_calc (
    input  logic                                i_clk,
    input  ppstop_pkg::t_calc_op                i_op,
    input  ppstop_pkg::t_pos                    i_a,
    input  ppstop_pkg::t_pos                    i_b,
    input  logic [ppstop_pkg::LIM_BITS-1:0]     i_lim_xy,
    input  logic [ppstop_pkg::LIM_BITS-1:0]     i_lim_z,
    output logic                                o_close
);

    logic [ppstop_pkg::COORD_BITS-1:0] r_dx;
    logic [ppstop_pkg::COORD_BITS-1:0] r_dy;
    logic [ppstop_pkg::COORD_BITS-1:0] r_dz;
    logic [ppstop_pkg::PROD_W-1:0]     r_prod;
    logic [ppstop_pkg::PROD_W-1:0]     r_acc;
    logic [ppstop_pkg::PROD_W-1:0]     r_lim2;
    logic [ppstop_pkg::OPW-1:0]        w_opnd;
    logic [ppstop_pkg::PROD_W-1:0]     w_prod;
    logic [ppstop_pkg::PROD_W:0]       w_sum;

    // Absolute difference of two signed coordinates; it always fits unsigned.
    function automatic logic [ppstop_pkg::COORD_BITS-1:0] abs_diff(
        input logic signed [ppstop_pkg::COORD_BITS-1:0] a,
        input logic signed [ppstop_pkg::COORD_BITS-1:0] b
    );
        logic signed [ppstop_pkg::COORD_BITS:0] d;
        d = $signed({a[ppstop_pkg::COORD_BITS-1], a}) - $signed({b[ppstop_pkg::COORD_BITS-1], b});
        abs_diff = d[ppstop_pkg::COORD_BITS] ? ppstop_pkg::COORD_BITS'(-d)
                                             : ppstop_pkg::COORD_BITS'(d);
    endfunction

    // Operand select for the shared squarer.
    always_comb begin
        case (i_op)
            ppstop_pkg::OP_LIM: w_opnd = ppstop_pkg::OPW'(i_lim_xy);
            ppstop_pkg::OP_SQX: w_opnd = ppstop_pkg::OPW'(r_dx);
            ppstop_pkg::OP_SQY: w_opnd = ppstop_pkg::OPW'(r_dy);
            default:            w_opnd = '0;
        endcase
    end

    assign w_prod = ppstop_pkg::PROD_W'(w_opnd) * ppstop_pkg::PROD_W'(w_opnd);

    // Datapath registers, each step loads its own result.
    always_ff @(posedge i_clk) begin
        case (i_op)
            ppstop_pkg::OP_LIM: begin
                r_lim2 <= w_prod;
            end
            ppstop_pkg::OP_DIFF: begin
                r_dx <= abs_diff(i_a.x, i_b.x);
                r_dy <= abs_diff(i_a.y, i_b.y);
                r_dz <= abs_diff(i_a.z, i_b.z);
            end
            ppstop_pkg::OP_SQX: begin
                r_prod <= w_prod;
            end
            ppstop_pkg::OP_SQY: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            default: begin
            end
        endcase
    end

    // Squared horizontal distance against the squared limit, plus the z test.
    assign w_sum   = {1'b0, r_acc} + {1'b0, r_prod};
    assign o_close = (w_sum < {1'b0, r_lim2}) &&
                     (ppstop_pkg::OPW'(r_dz) < ppstop_pkg::OPW'(i_lim_z));

endmodule

// File: design/ppstop_ctrl.sv
`timescale 1ns / 1ps

module ppstop_ctrl (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_kind,
    input  logic [ppstop_pkg::VIDX_BITS-1:0]      i_vehicle_index,
    input  logic [ppstop_pkg::VIN_BITS-1:0]       i_vin,
    input  logic [ppstop_pkg::MAX_VEHICLES-1:0]   i_valid_bits,
    input  logic                                  i_close,
    output ppstop_pkg::t_store_ctl                o_store_ctl,
    output ppstop_pkg::t_calc_op                  o_op,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ppstop_pkg::STOP_BITS-1:0]      o_stop_mask
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LIM  = 8'b0000_0010,
        S_READ = 8'b0000_0100,
        S_DIFF = 8'b0000_1000,
        S_SQX  = 8'b0001_0000,
        S_SQY  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state                              r_state, n_state;
    logic [ppstop_pkg::CNT_BITS-1:0]     r_i, n_i;
    logic [ppstop_pkg::CNT_BITS-1:0]     r_j, n_j;
    logic [ppstop_pkg::MASK_W-1:0]       r_mask, n_mask;
    logic                                r_out_valid, n_out_valid;
    logic [ppstop_pkg::STOP_BITS-1:0]    r_out_mask, n_out_mask;

    logic [ppstop_pkg::CNT_BITS-1:0]     w_n;
    logic [ppstop_pkg::CNT_BITS-1:0]     w_j_inc;
    logic [ppstop_pkg::CNT_BITS-1:0]     w_i_inc;
    logic [ppstop_pkg::CNT_BITS-1:0]     w_i_inc2;
    logic                                w_more;
    logic [ppstop_pkg::CNT_BITS-1:0]     w_next_i;
    logic [ppstop_pkg::CNT_BITS-1:0]     w_next_j;
    logic                                w_pair_valid;

    // Entries taking part, saturated to the table size.
    assign w_n = (int'(i_vin) > ppstop_pkg::MAX_VEHICLES)
               ? ppstop_pkg::CNT_BITS'(ppstop_pkg::MAX_VEHICLES)
               : ppstop_pkg::CNT_BITS'(i_vin);

    // Next pair (i, j) with i < j < n, row by row.
    assign w_j_inc  = r_j + ppstop_pkg::CNT_BITS'(1);
    assign w_i_inc  = r_i + ppstop_pkg::CNT_BITS'(1);
    assign w_i_inc2 = r_i + ppstop_pkg::CNT_BITS'(2);

    always_comb begin
        if (w_j_inc < w_n) begin
            w_more   = 1'b1;
            w_next_i = r_i;
            w_next_j = w_j_inc;
        end else if (w_i_inc2 < w_n) begin
            w_more   = 1'b1;
            w_next_i = w_i_inc;
            w_next_j = w_i_inc2;
        end else begin
            w_more   = 1'b0;
            w_next_i = r_i;
            w_next_j = r_j;
        end
    end

    assign w_pair_valid = i_valid_bits[r_i[ppstop_pkg::IDX_BITS-1:0]] &&
                          i_valid_bits[r_j[ppstop_pkg::IDX_BITS-1:0]];

    // Sequencer for updates and the pair scan.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_mask  = r_out_mask;
        o_op        = ppstop_pkg::OP_NONE;
        o_store_ctl.we      = 1'b0;
        o_store_ctl.waddr   = ppstop_pkg::IDX_BITS'(i_vehicle_index);
        o_store_ctl.raddr_a = r_i[ppstop_pkg::IDX_BITS-1:0];
        o_store_ctl.raddr_b = r_j[ppstop_pkg::IDX_BITS-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind) begin
                        n_state = S_LIM;
                        n_i     = '0;
                        n_j     = ppstop_pkg::CNT_BITS'(1);
                        n_mask  = '0;
                    end else if (int'(i_vehicle_index) < int'(w_n)) begin
                        o_store_ctl.we = 1'b1;
                    end
                end
            end
            S_LIM: begin
                o_op    = ppstop_pkg::OP_LIM;
                n_state = (w_n >= ppstop_pkg::CNT_BITS'(2)) ? S_READ : S_OUT;
            end
            S_READ: begin
                // Pairs with an invalid entry are skipped here, without the calculation steps.
                if (w_pair_valid) begin
                    n_state = S_DIFF;
                end else if (w_more) begin
                    n_i = w_next_i;
                    n_j = w_next_j;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIFF: begin
                o_op    = ppstop_pkg::OP_DIFF;
                n_state = S_SQX;
            end
            S_SQX: begin
                o_op    = ppstop_pkg::OP_SQX;
                n_state = S_SQY;
            end
            S_SQY: begin
                o_op    = ppstop_pkg::OP_SQY;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_close) begin
                    n_mask = r_mask | (ppstop_pkg::MASK_W'(1) << r_i)
                                    | (ppstop_pkg::MASK_W'(1) << r_j);
                end
                if (w_more) begin
                    n_i     = w_next_i;
                    n_j     = w_next_j;
                    n_state = S_READ;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hand the mask to the output register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = r_mask[ppstop_pkg::STOP_BITS-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Scan counters and masks.
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_mask     <= n_mask;
        r_out_mask <= n_out_mask;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_stop_mask = r_out_mask;

endmodule

// File: design/pairwise_proximity_stop_unit.sv
`timescale 1ns / 1ps

// Pairwise proximity stop unit. A position update word (kind 0) writes x, y, z
// for one vehicle and marks it valid; it is taken one per cycle while the unit
// is idle, gives no result, and is dropped when vehicle_index is not below
// vehicles_in_use. A tick word (kind 1) scans every pair of valid entries among
// the first vehicles_in_use and returns one stop_mask word with both bits of
// each too-close pair set. The scan runs on one shared squarer under a small
// sequencer: a tick holds the input stalled while pairs are scanned, and also
// while the previous mask still sits stalled in the output register, since the
// new mask waits for that register to free up. Each valid pair goes through a
// table read, the differences, two squarings and one compare; a pair with an
// invalid entry is skipped after the table check. A finished mask waits in the
// output register while the next words are accepted. Configuration must be
// written only while the unit is idle; the block itself does not enforce this.
module pairwise_proximity_stop_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [ppstop_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [ppstop_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_kind,
    input  logic [ppstop_pkg::VIDX_BITS-1:0]         i_vehicle_index,
    input  logic signed [ppstop_pkg::COORD_BITS-1:0] i_pos_x,
    input  logic signed [ppstop_pkg::COORD_BITS-1:0] i_pos_y,
    input  logic signed [ppstop_pkg::COORD_BITS-1:0] i_pos_z,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [ppstop_pkg::STOP_BITS-1:0]         o_stop_mask
);

    logic [ppstop_pkg::LIM_BITS-1:0]      r_lim_xy;
    logic [ppstop_pkg::LIM_BITS-1:0]      r_lim_z;
    logic [ppstop_pkg::VIN_BITS-1:0]      r_vin;

    ppstop_pkg::t_store_ctl               w_store_ctl;
    ppstop_pkg::t_calc_op                 w_op;
    ppstop_pkg::t_pos                     w_wdata;
    ppstop_pkg::t_pos                     w_rdata_a;
    ppstop_pkg::t_pos                     w_rdata_b;
    logic [ppstop_pkg::MAX_VEHICLES-1:0]  w_valid_bits;
    logic                                 w_close;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_xy <= '0;
            r_lim_z  <= '0;
            r_vin    <= ppstop_pkg::VIN_RESET;
        end else if (i_cfg_we) begin
            case (ppstop_pkg::t_cfg_idx'(i_cfg_index))
                ppstop_pkg::CFG_LIM_XY: r_lim_xy <= i_cfg_data[ppstop_pkg::LIM_BITS-1:0];
                ppstop_pkg::CFG_LIM_Z:  r_lim_z  <= i_cfg_data[ppstop_pkg::LIM_BITS-1:0];
                ppstop_pkg::CFG_VIN:    r_vin    <= i_cfg_data[ppstop_pkg::VIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_wdata.x = i_pos_x;
    assign w_wdata.y = i_pos_y;
    assign w_wdata.z = i_pos_z;

    ppstop_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_vehicle_index (i_vehicle_index),
        .i_vin           (r_vin),
        .i_valid_bits    (w_valid_bits),
        .i_close         (w_close),
        .o_store_ctl     (w_store_ctl),
        .o_op            (w_op),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_stop_mask     (o_stop_mask)
    );

    ppstop_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_store_ctl),
        .i_wdata   (w_wdata),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b),
        .o_valid   (w_valid_bits)
    );

    ppstop_calc u_calc (
        .i_clk    (i_clk),
        .i_op     (w_op),
        .i_a      (w_rdata_a),
        .i_b      (w_rdata_b),
        .i_lim_xy (r_lim_xy),
        .i_lim_z  (r_lim_z),
        .o_close  (w_close)
    );

endmodule

// File: design/ppstop_checker.sv
`timescale 1ns / 1ps

module ppstop_checker (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  logic                                     o_in_stall,
    input  logic                                     i_kind,
    input  logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    input  logic [ppstop_pkg::STOP_BITS-1:0]         o_stop_mask
);

    // A stalled result word stays valid.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result word dropped");

    // A stalled result word keeps its value.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_stop_mask))
        else $error("stalled result word changed");

    // An update word leaves the unit ready in the next cycle.
    a_update_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_kind) |=> !o_in_stall)
        else $error("unit busy after an update word");

    // A tick word starts a scan, so the input stalls next.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind) |=> o_in_stall)
        else $error("unit ready right after a tick word");

    // Stop bits come in pairs, so a mask never has a single bit set.
    a_mask_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$onehot(o_stop_mask))
        else $error("stop mask with a single bit set");

endmodule

bind pairwise_proximity_stop_unit ppstop_checker u_ppstop_checker (.*);
